[rtl/core/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared constants and types for the SLIP frame decoder: link byte codes,
// result status codes, buffer geometry and the buffer write and read requests.
// ----------------------------------------------------------------------------
package sfd_pkg;

  // Frame buffer geometry. The frame length output is 7 bits wide, so the
  // depth stays at 64 entries.
  localparam int unsigned FRAME_DEPTH = 64;
  localparam int unsigned ADDR_W      = $clog2(FRAME_DEPTH);
  localparam int unsigned CNT_W       = $clog2(FRAME_DEPTH + 1);

  // Special byte values of the SLIP line coding.
  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  // Status carried with every result.
  typedef enum logic [1:0] {
    ST_DATA     = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_BAD_ESC  = 2'd2
  } status_e;

  // One write into the frame buffer.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        data;
  } sfd_wr_t;

  // One read from the frame buffer.
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
  } sfd_rd_t;

endpackage

[rtl/core/sfd_frame_buf.sv]
// ----------------------------------------------------------------------------
// sfd_frame_buf
// Single-clock frame buffer: one write port, one read port with a registered
// read data output.
// ----------------------------------------------------------------------------
module sfd_frame_buf (
  input  logic            clk_i,
  input  sfd_pkg::sfd_wr_t wr_i,
  input  sfd_pkg::sfd_rd_t rd_i,
  output logic [7:0]      rd_data_o
);

  logic [7:0] mem_q [sfd_pkg::FRAME_DEPTH];
  logic [7:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  // Read data holds its value while no read is issued.
  always_ff @(posedge clk_i) begin
    if (rd_i.en) begin
      rd_data_q <= mem_q[rd_i.addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[rtl/core/slip_frame_decoder.sv]
// ----------------------------------------------------------------------------
// slip_frame_decoder
// Receive-side SLIP decoder: removes escaping, collects the decoded bytes of
// one frame in a buffer and plays the frame out byte by byte on END.
// ----------------------------------------------------------------------------
// Usage:
// - Input channel (rx_valid_i / rx_stall_o / rx_byte_i) carries one raw link
//   byte per request. A data byte or an escape sequence is absorbed and written
//   into the frame buffer; no result is produced for it unless it overflows.
// - Output channel (out_valid_o / out_stall_i) carries one result per request:
//   a frame byte with its status, last-byte mark and frame length, or a single
//   error result (overflow or bad escape) after which the frame is dropped.
// - An END byte closing a frame of n >= 2 bytes starts the playout. Each byte
//   is read from the buffer in S_READ and loaded into the output register in
//   S_LOAD, which waits while the receiver stalls a held result. The input
//   is stalled for the whole playout.
// - Results leave through an output register, so an error result appears in
//   the cycle after its request; a frame byte goes through S_READ and S_LOAD.
// - The input is also stalled while a finished result waits in the output
//   register and the receiver stalls it, since the next byte might need it.
// - Configuration (cfg_valid_i / cfg_ready_o / cfg_frame_limit_i) writes the
//   frame limit; it is always ready and must only be written while idle.
//   Limits above the buffer depth act as the buffer depth.
// - Reset clears the byte count, the escape flag and the output valid flag and
//   sets the frame limit to 64. Buffer contents are not cleared: only entries
//   written in the current frame are ever read.
// ----------------------------------------------------------------------------
module slip_frame_decoder (
  input  logic       clk_i,
  input  logic       rst_ni,
  // Raw link bytes in
  input  logic       rx_valid_i,
  output logic       rx_stall_o,
  input  logic [7:0] rx_byte_i,
  // Decoded results out
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [1:0] status_o,
  output logic [7:0] frame_byte_o,
  output logic       last_byte_o,
  output logic [6:0] frame_length_o,
  // Frame limit register write
  input  logic       cfg_valid_i,
  output logic       cfg_ready_o,
  input  logic [6:0] cfg_frame_limit_i
);

  localparam int unsigned CW = sfd_pkg::CNT_W;
  localparam int unsigned AW = sfd_pkg::ADDR_W;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_READ = 3'b010,
    S_LOAD = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [6:0]      limit_q;
  logic [CW-1:0]   fill_q, fill_d;
  logic            esc_q, esc_d;
  logic [CW-1:0]   rd_idx_q, rd_idx_d;
  logic [CW-1:0]   emit_len_q, emit_len_d;

  // Output register
  logic            out_valid_q, out_valid_d;
  sfd_pkg::status_e status_q, status_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;
  logic [CW-1:0]   len_q, len_d;
  logic            out_load;

  sfd_pkg::sfd_wr_t wr;
  sfd_pkg::sfd_rd_t rd;
  logic [7:0]       rd_data;

  logic            rx_fire;
  logic            out_free;
  logic [CW-1:0]   eff_limit;
  logic [CW-1:0]   close_len;
  logic            do_store;
  logic [7:0]      store_byte;

  sfd_frame_buf u_buf (
    .clk_i     (clk_i),
    .wr_i      (wr),
    .rd_i      (rd),
    .rd_data_o (rd_data)
  );

  // The output register can take a new result when it is empty or its
  // current result is being taken in this cycle.
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rx_stall_o = (state_q != S_IDLE) || !out_free;
  assign rx_fire    = rx_valid_i && !rx_stall_o;

  assign cfg_ready_o = 1'b1;

  // Limits beyond the buffer depth behave as the depth itself.
  assign eff_limit = (limit_q > CW'(sfd_pkg::FRAME_DEPTH)) ?
                     CW'(sfd_pkg::FRAME_DEPTH) : limit_q;
  assign close_len = (fill_q > eff_limit) ? eff_limit : fill_q;

  always_comb begin
    state_d    = state_q;
    fill_d     = fill_q;
    esc_d      = esc_q;
    rd_idx_d   = rd_idx_q;
    emit_len_d = emit_len_q;
    out_load   = 1'b0;
    status_d   = sfd_pkg::ST_DATA;
    byte_d     = 8'd0;
    last_d     = 1'b0;
    len_d      = '0;
    do_store   = 1'b0;
    store_byte = rx_byte_i;
    rd.en      = 1'b0;
    rd.addr    = rd_idx_q[AW-1:0];

    case (state_q)
      S_IDLE: begin
        if (rx_fire) begin
          if (esc_q) begin
            if (rx_byte_i == sfd_pkg::SLIP_ESC_END) begin
              do_store   = 1'b1;
              store_byte = sfd_pkg::SLIP_END;
            end else if (rx_byte_i == sfd_pkg::SLIP_ESC_ESC) begin
              do_store   = 1'b1;
              store_byte = sfd_pkg::SLIP_ESC;
            end else begin
              out_load = 1'b1;
              status_d = sfd_pkg::ST_BAD_ESC;
              fill_d   = '0;
              esc_d    = 1'b0;
            end
          end else if (rx_byte_i == sfd_pkg::SLIP_END) begin
            fill_d = '0;
            esc_d  = 1'b0;
            if (close_len >= CW'(2)) begin
              emit_len_d = close_len;
              rd_idx_d   = '0;
              state_d    = S_READ;
            end
          end else if (rx_byte_i == sfd_pkg::SLIP_ESC) begin
            esc_d = 1'b1;
          end else begin
            do_store = 1'b1;
          end

          if (do_store) begin
            esc_d = 1'b0;
            if (fill_q >= eff_limit) begin
              out_load = 1'b1;
              status_d = sfd_pkg::ST_OVERFLOW;
              fill_d   = '0;
            end else begin
              fill_d = fill_q + CW'(1);
            end
          end
        end
      end

      S_READ: begin
        rd.en   = 1'b1;
        state_d = S_LOAD;
      end

      S_LOAD: begin
        if (out_free) begin
          out_load = 1'b1;
          byte_d   = rd_data;
          len_d    = emit_len_q;
          if (rd_idx_q + CW'(1) == emit_len_q) begin
            last_d  = 1'b1;
            state_d = S_IDLE;
          end else begin
            rd_idx_d = rd_idx_q + CW'(1);
            state_d  = S_READ;
          end
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // A store is only written when the count is below the limit, which is at
  // most the buffer depth, so the count fits the address.
  assign wr.en   = do_store && (fill_q < eff_limit);
  assign wr.addr = fill_q[AW-1:0];
  assign wr.data = store_byte;

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      limit_q     <= 7'd64;
      fill_q      <= '0;
      esc_q       <= 1'b0;
      rd_idx_q    <= '0;
      emit_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      fill_q      <= fill_d;
      esc_q       <= esc_d;
      rd_idx_q    <= rd_idx_d;
      emit_len_q  <= emit_len_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        limit_q <= cfg_frame_limit_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      status_q <= status_d;
      byte_q   <= byte_d;
      last_q   <= last_d;
      len_q    <= len_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = status_q;
  assign frame_byte_o   = byte_q;
  assign last_byte_o    = last_q;
  assign frame_length_o = len_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // Playout only reads entries that belong to the frame being emitted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_READ) |-> (rd_idx_q < emit_len_q))
    else $error("frame buffer read beyond frame length");

  // A frame under playout always holds at least two bytes and fits the buffer.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |->
      (emit_len_q >= CW'(2) && emit_len_q <= CW'(sfd_pkg::FRAME_DEPTH)))
    else $error("playout length out of range");

  // The byte count never passes the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= CW'(sfd_pkg::FRAME_DEPTH))
    else $error("fill count beyond buffer depth");

  // Leaving playout always leaves the marked last byte in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD && state_d == S_IDLE) |=> (out_valid_q && last_q))
    else $error("playout ended without a last byte");

endmodule

[tb/slip_frame_decoder_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// slip_frame_decoder_tb
// Self-checking bench for the SLIP frame decoder. Raw link bytes are fed from
// a queue through a bursty driver. An untimed predictor decodes every
// accepted request and keeps the results it expects. The monitor checks each
// accepted result against the oldest expectation, field by field. The frame
// limit is rewritten between phases while the block is idle.
// ----------------------------------------------------------------------------
module slip_frame_decoder_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE_CYCLES = 6;
  localparam int HOLD_CYCLES = 300;

  // One decoded result as it should appear on the output channel.
  typedef struct packed {
    sfd_pkg::status_e status;
    logic [7:0]       data;
    logic             last;
    logic [6:0]       length;
  } frame_result_t;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = 8'h00;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [1:0] status_o;
  logic [7:0] frame_byte_o;
  logic       last_byte_o;
  logic [6:0] frame_length_o;
  logic       cfg_valid_i = 1'b0;
  logic       cfg_ready_o;
  logic [6:0] cfg_frame_limit_i = 7'd0;

  slip_frame_decoder u_dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .rx_valid_i        (rx_valid_i),
    .rx_stall_o        (rx_stall_o),
    .rx_byte_i         (rx_byte_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .status_o          (status_o),
    .frame_byte_o      (frame_byte_o),
    .last_byte_o       (last_byte_o),
    .frame_length_o    (frame_length_o),
    .cfg_valid_i       (cfg_valid_i),
    .cfg_ready_o       (cfg_ready_o),
    .cfg_frame_limit_i (cfg_frame_limit_i)
  );

  always #5 clk_i = ~clk_i;

  // Link bytes waiting to be offered, and results the predictor expects.
  logic [7:0]    link_bytes_q[$];
  frame_result_t decoded_q[$];

  // Predictor copy of the decoder state.
  logic [7:0] frame_buf [sfd_pkg::FRAME_DEPTH];
  logic [6:0] fill_cnt = '0;
  logic       esc_pend = 1'b0;
  logic [6:0] frame_limit_q = 7'd64;

  int   error_cnt = 0;
  int   cycle_cnt = 0;
  logic rx_taken = 1'b0;
  logic cfg_seen = 1'b0;

  // Stimulus side view of the limit, used to size frames.
  int   cur_limit = 64;
  int   queued_total = 0;

  // Driver burst state.
  int   burst_left = 0;
  int   gap_left = 0;

  // Receiver stall state. A hold request from the stimulus makes the stall
  // process keep the output stalled for a long stretch on its own count.
  logic       stall_hold_req = 1'b0;
  int         hold_left = 0;
  int         stall_mode = 0;
  int         seg_left = 0;
  logic [7:0] stall_mask = 8'h00;
  logic [2:0] stall_phase = 3'd0;

  function automatic int eff_limit(input int lim);
    return (lim > sfd_pkg::FRAME_DEPTH) ? sfd_pkg::FRAME_DEPTH : lim;
  endfunction

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic drop_frame(input sfd_pkg::status_e code);
    frame_result_t r;
    r.status = code;
    r.data   = 8'h00;
    r.last   = 1'b0;
    r.length = 7'd0;
    decoded_q.push_back(r);
    fill_cnt = '0;
    esc_pend = 1'b0;
  endtask

  task automatic store_decoded(input logic [7:0] b);
    if (fill_cnt >= eff_limit(frame_limit_q)) begin
      drop_frame(sfd_pkg::ST_OVERFLOW);
    end else begin
      if (fill_cnt < sfd_pkg::FRAME_DEPTH) frame_buf[fill_cnt[sfd_pkg::ADDR_W-1:0]] = b;
      fill_cnt = fill_cnt + 1'b1;
      esc_pend = 1'b0;
    end
  endtask

  // Decodes one accepted link byte and queues the results it causes.
  task automatic slip_decode_byte(input logic [7:0] b);
    frame_result_t r;
    int n;
    if (esc_pend) begin
      if (b == sfd_pkg::SLIP_ESC_END) store_decoded(sfd_pkg::SLIP_END);
      else if (b == sfd_pkg::SLIP_ESC_ESC) store_decoded(sfd_pkg::SLIP_ESC);
      else drop_frame(sfd_pkg::ST_BAD_ESC);
    end else if (b == sfd_pkg::SLIP_END) begin
      // A frame shorter than two bytes closes silently.
      n = fill_cnt;
      if (n > eff_limit(frame_limit_q)) n = eff_limit(frame_limit_q);
      if (n >= 2) begin
        for (int i = 0; i < n; i++) begin
          r.status = sfd_pkg::ST_DATA;
          r.data   = frame_buf[i[sfd_pkg::ADDR_W-1:0]];
          r.last   = (i == n - 1);
          r.length = n[6:0];
          decoded_q.push_back(r);
        end
      end
      fill_cnt = '0;
      esc_pend = 1'b0;
    end else if (b == sfd_pkg::SLIP_ESC) begin
      esc_pend = 1'b1;
    end else begin
      store_decoded(b);
    end
  endtask

  // ---------------------------------------------------------------------------
  // Monitor
  // ---------------------------------------------------------------------------

  task automatic report_field(input string name, input int want, input int got);
    error_cnt++;
    if (error_cnt <= 50)
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
  endtask

  task automatic check_result();
    frame_result_t want;
    if (decoded_q.size() == 0) begin
      error_cnt++;
      if (error_cnt <= 50)
        $display("%0t: unexpected result, expected none, actual status %0d byte %02h",
                 $time, status_o, frame_byte_o);
    end else begin
      want = decoded_q.pop_front();
      if (status_o !== want.status) report_field("status", want.status, status_o);
      if (frame_byte_o !== want.data) report_field("frame_byte", want.data, frame_byte_o);
      if (last_byte_o !== want.last) report_field("last_byte", want.last, last_byte_o);
      if (frame_length_o !== want.length)
        report_field("frame_length", want.length, frame_length_o);
    end
  endtask

  // Everything is sampled at the rising edge: results are checked before the
  // request of the same edge is decoded, since a result never leaves in the
  // cycle its request is taken.
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    rx_taken  <= rst_ni && rx_valid_i && !rx_stall_o;
    cfg_seen  <= rst_ni && cfg_valid_i && cfg_ready_o;
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) check_result();
      if (rx_valid_i && !rx_stall_o) slip_decode_byte(rx_byte_i);
      if (cfg_valid_i && cfg_ready_o) frame_limit_q = cfg_frame_limit_i;
    end
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Driver: offers queued link bytes in bursts with random gaps. A request
  // stays up, unchanged, until it is taken.
  // ---------------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (!rx_valid_i || rx_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        rx_valid_i <= 1'b0;
      end else if (link_bytes_q.size() > 0) begin
        rx_valid_i <= 1'b1;
        rx_byte_i  <= link_bytes_q.pop_front();
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(0, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        rx_valid_i <= 1'b0;
      end
    end
  end

  // Receiver: runs segments of no stall, random stall and a repeating mask, or holds the stall on request.
  always @(negedge clk_i) begin
    stall_phase <= stall_phase + 1'b1;
    if (hold_left > 0) begin
      hold_left   <= hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (stall_hold_req) begin
      hold_left   <= HOLD_CYCLES;
      out_stall_i <= 1'b1;
    end else begin
      if (seg_left == 0) begin
        stall_mode = $urandom_range(0, 2);
        seg_left   = $urandom_range(8, 60);
        stall_mask = 8'($urandom_range(0, 255));
      end else begin
        seg_left--;
      end
      case (stall_mode)
        0: begin
          out_stall_i <= 1'b0;
        end
        1: begin
          out_stall_i <= ($urandom_range(0, 99) < 40);
        end
        default: begin
          out_stall_i <= stall_mask[stall_phase];
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic void push_link(input logic [7:0] b);
    link_bytes_q.push_back(b);
    queued_total++;
  endfunction

  // Queues one decoded byte in line coding, escaping END and ESC.
  function automatic void push_decoded(input logic [7:0] b);
    if (b == sfd_pkg::SLIP_END) begin
      push_link(sfd_pkg::SLIP_ESC);
      push_link(sfd_pkg::SLIP_ESC_END);
    end else if (b == sfd_pkg::SLIP_ESC) begin
      push_link(sfd_pkg::SLIP_ESC);
      push_link(sfd_pkg::SLIP_ESC_ESC);
    end else begin
      push_link(b);
    end
  endfunction

  function automatic logic [7:0] rand_payload();
    logic [7:0] specials [4] = '{sfd_pkg::SLIP_END, sfd_pkg::SLIP_ESC,
                                 sfd_pkg::SLIP_ESC_END, sfd_pkg::SLIP_ESC_ESC};
    if ($urandom_range(0, 3) == 0) return specials[2'($urandom_range(0, 3))];
    return 8'($urandom_range(0, 255));
  endfunction

  // Queues a frame of len decoded bytes, closed by END when close is set.
  function automatic void queue_frame(input int len, input bit close);
    for (int i = 0; i < len; i++) push_decoded(rand_payload());
    if (close) push_link(sfd_pkg::SLIP_END);
  endfunction

  // Random traffic: mostly well-formed frames with random content, the rest
  // broken escapes, unterminated frames and raw noise.
  task automatic random_traffic(input int budget);
    int stop_at;
    int kind;
    int len;
    logic [7:0] b;
    stop_at = queued_total + budget;
    while (queued_total < stop_at) begin
      kind = $urandom_range(0, 9);
      if (kind <= 6) begin
        len = $urandom_range(0, 9);
        if (len < 8) len = $urandom_range(2, 7);
        else if (len == 8) len = $urandom_range(0, 1);
        else len = eff_limit(cur_limit) + $urandom_range(0, 1);
        if (len > 16 && $urandom_range(0, 2) != 0) len = $urandom_range(2, 5);
        queue_frame(len, 1'b1);
      end else if (kind == 7) begin
        // Escape followed by a byte that is not an escape code.
        queue_frame($urandom_range(0, 3), 1'b0);
        push_link(sfd_pkg::SLIP_ESC);
        do begin
          if ($urandom_range(0, 2) == 0) begin
            b = ($urandom_range(0, 1) == 1) ? sfd_pkg::SLIP_END : sfd_pkg::SLIP_ESC;
          end else begin
            b = 8'($urandom_range(0, 255));
          end
        end while (b == sfd_pkg::SLIP_ESC_END || b == sfd_pkg::SLIP_ESC_ESC);
        push_link(b);
      end else if (kind == 8) begin
        queue_frame($urandom_range(1, 4), 1'b0);
      end else begin
        repeat ($urandom_range(1, 4)) push_link(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Waits until the queue is empty and every expected result has arrived,
  // then lets the block settle on any byte that caused no result. The check
  // runs at the rising edge, where the driver's last update has settled.
  task automatic wait_idle(input int settle);
    do @(posedge clk_i);
    while (link_bytes_q.size() != 0 || rx_valid_i || decoded_q.size() != 0);
    repeat (settle) @(negedge clk_i);
  endtask

  // Writes the frame limit; called at a falling edge while idle.
  task automatic write_limit(input logic [6:0] lim);
    cfg_valid_i       <= 1'b1;
    cfg_frame_limit_i <= lim;
    do @(negedge clk_i);
    while (!cfg_seen);
    cfg_valid_i <= 1'b0;
    cur_limit = lim;
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(negedge clk_i);

    // Directed requests at the reset limit: empty and one-byte frames stay
    // silent, both escape codes decode, and every kind of bad escape drops.
    push_link(sfd_pkg::SLIP_END);
    push_link(8'h00);
    push_link(sfd_pkg::SLIP_END);
    push_link(8'h00);
    push_link(8'hFF);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_ESC_END);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_ESC_ESC);
    push_link(sfd_pkg::SLIP_END);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(8'h41);
    push_link(8'h11);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_END);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(8'h22);
    push_link(8'h33);
    push_link(sfd_pkg::SLIP_END);
    wait_idle(SETTLE_CYCLES);

    // Limit of two: plain and escaped bytes both overflow.
    write_limit(7'd2);
    push_link(8'h01);
    push_link(8'h02);
    push_link(8'h03);
    push_link(sfd_pkg::SLIP_END);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_ESC_END);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_ESC_ESC);
    push_link(sfd_pkg::SLIP_ESC);
    push_link(sfd_pkg::SLIP_ESC_END);
    push_link(8'hAA);
    push_link(8'hBB);
    push_link(sfd_pkg::SLIP_END);
    wait_idle(SETTLE_CYCLES);

    // A limit of zero makes every store overflow.
    write_limit(7'd0);
    push_link(8'h55);
    push_link(sfd_pkg::SLIP_END);
    random_traffic(4);
    wait_idle(SETTLE_CYCLES);

    // Limit above the buffer depth: one frame of the full depth.
    write_limit(7'd127);
    queue_frame(sfd_pkg::FRAME_DEPTH, 1'b1);
    wait_idle(SETTLE_CYCLES);

    write_limit(7'($urandom_range(3, 63)));
    random_traffic(10);
    wait_idle(SETTLE_CYCLES);

    write_limit(7'd1);
    random_traffic(8);
    wait_idle(SETTLE_CYCLES);

    // Long receiver hold while frames keep coming, so the output register
    // fills and the block stalls its input.
    write_limit(7'd64);
    @(posedge clk_i);
    stall_hold_req = 1'b1;
    queue_frame(8, 1'b1);
    queue_frame(6, 1'b1);
    random_traffic(4);
    while (hold_left == 0) @(posedge clk_i);
    stall_hold_req = 1'b0;
    wait_idle(SETTLE_CYCLES);

    // Small limit with a frame one byte over it.
    write_limit(7'($urandom_range(2, 8)));
    random_traffic(6);
    queue_frame(eff_limit(cur_limit) + 1, 1'b1);
    wait_idle(SETTLE_CYCLES);

    // Back to the reset value.
    write_limit(7'd64);
    random_traffic(4);
    wait_idle(SETTLE_CYCLES + 10);

    if (error_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/sfd_pkg.sv
rtl/core/sfd_frame_buf.sv
rtl/core/slip_frame_decoder.sv
tb/slip_frame_decoder_tb.sv
